/* sv/assert_macros.svh */
// Assertion macros used by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check cons in the same cycle whenever ante holds
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// check cons in the cycle after ante holds
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

/* sv/utf8v_pkg.sv */
// Types, constants and byte classification for the UTF-8 stream validator
package utf8v_pkg;

	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_END  = 1'b1;

	localparam int MAX_RESULTS = 4;
	localparam int CARRY_DEPTH = 3;

	localparam logic [7:0] ASCII_MAX  = 8'h7F;
	localparam logic [7:0] LEAD2_MIN  = 8'hC2;
	localparam logic [7:0] LEAD2_MAX  = 8'hDF;
	localparam logic [7:0] LEAD3_MIN  = 8'hE0;
	localparam logic [7:0] LEAD3_MAX  = 8'hEF;
	localparam logic [7:0] LEAD4_MIN  = 8'hF0;
	localparam logic [7:0] LEAD4_MAX  = 8'hF4;
	localparam logic [7:0] CONT_MIN   = 8'h80;
	localparam logic [7:0] CONT_MAX   = 8'hBF;
	localparam logic [7:0] SECOND_A0  = 8'hA0;
	localparam logic [7:0] LEAD_SURR  = 8'hED;
	localparam logic [7:0] SECOND_90  = 8'h90;

	typedef enum logic [1:0] {
		ST_BYTE       = 2'd0,
		ST_INVALID    = 2'd1,
		ST_INCOMPLETE = 2'd2,
		ST_DONE       = 2'd3
	} stat_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       char_end;
		stat_t      status;
	} result_t;

	function automatic logic [2:0] lead_width(input logic [7:0] b);
		logic [2:0] w;
		w = 3'd0;
		if (b <= ASCII_MAX) begin
			w = 3'd1;
		end else if (b inside {[LEAD2_MIN:LEAD2_MAX]}) begin
			w = 3'd2;
		end else if (b inside {[LEAD3_MIN:LEAD3_MAX]}) begin
			w = 3'd3;
		end else if (b inside {[LEAD4_MIN:LEAD4_MAX]}) begin
			w = 3'd4;
		end
		return w;
	endfunction

	function automatic logic is_cont(input logic [7:0] b);
		return (b >= CONT_MIN) && (b <= CONT_MAX);
	endfunction

	function automatic logic char_ok(input logic [7:0] c0, input logic [7:0] c1,
			input logic [7:0] c2, input logic [7:0] c3, input logic [2:0] w);
		logic ok;
		ok = is_cont(c1);
		if (w >= 3'd3 && !is_cont(c2)) ok = 1'b0;
		if (w >= 3'd4 && !is_cont(c3)) ok = 1'b0;
		if (c0 == LEAD3_MIN && c1 < SECOND_A0) ok = 1'b0;
		if (c0 == LEAD_SURR && c1 >= SECOND_A0) ok = 1'b0;
		if (c0 == LEAD4_MIN && c1 < SECOND_90) ok = 1'b0;
		if (c0 == LEAD4_MAX && c1 >= SECOND_90) ok = 1'b0;
		return ok;
	endfunction

endpackage

/* sv/utf8v_in_if.sv */
// Input channel: one stream byte or end marker per beat
interface utf8v_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] data_byte;

	modport source (output valid, output kind, output data_byte, input ready);
	modport sink (input valid, input kind, input data_byte, output ready);
endinterface

/* sv/utf8v_out_if.sv */
// Output channel: one validated byte or status result per beat
interface utf8v_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       char_end;
	logic [1:0] status;

	modport source (output valid, output out_byte, output char_end, output status, input ready);
	modport sink (input valid, input out_byte, input char_end, input status, output ready);
endinterface

/* sv/utf8_stream_validator_top.sv */
// Top level of the UTF-8 stream validator: input register, carry logic, result buffer
// A beat is registered in the input stage; its results, if any, go to the result buffer once it is free.
// Input takes one beat per cycle while the result buffer is free; results leave one per cycle while
// the output is ready, from a four-entry buffer, so a complete multi-byte character holds input until its bytes drain.
// Reset clears the input valid flag, the carry count and width, and the result buffer;
// held character bytes and buffered payload are not reset.
`include "assert_macros.svh"

module utf8_stream_validator_top (
	input  logic        clk,
	input  logic        arst_n,
	utf8v_in_if.sink    byte_ch,
	utf8v_out_if.source result_ch
);
	import utf8v_pkg::*;

	logic        valid_s1;
	logic        kind_s1;
	logic [7:0]  byte_s1;

	logic [7:0]  carry_bytes_q [CARRY_DEPTH];
	logic [1:0]  carry_count_q;
	logic [2:0]  char_width_q;

	result_t     res_q [MAX_RESULTS];
	logic [2:0]  rem_q;
	logic [1:0]  idx_q;

	logic        buf_free;
	logic        advance;
	logic        out_take;

	logic [1:0]  cnt_d;
	logic [2:0]  w_d;
	logic        wr_en;
	logic [1:0]  wr_idx;
	result_t     new_res [MAX_RESULTS];
	logic [2:0]  new_num;

	logic [2:0]  lw;
	logic [7:0]  c1;
	logic [7:0]  c2;
	logic        new_char;

	assign out_take = result_ch.valid && result_ch.ready;
	assign buf_free = (rem_q == 3'd0) || ((rem_q == 3'd1) && result_ch.ready);
	assign advance  = valid_s1 && buf_free;
	assign byte_ch.ready = !valid_s1 || buf_free;

	assign result_ch.valid    = (rem_q != 3'd0);
	assign result_ch.out_byte = res_q[idx_q].out_byte;
	assign result_ch.char_end = res_q[idx_q].char_end;
	assign result_ch.status   = res_q[idx_q].status;

	assign lw = lead_width(byte_s1);
	assign c1 = (carry_count_q == 2'd1) ? byte_s1 : carry_bytes_q[1];
	assign c2 = (carry_count_q == 2'd2) ? byte_s1 : carry_bytes_q[2];
	assign new_char = (carry_count_q == 2'd0) || (char_width_q < 3'd2)
		|| (char_width_q > 3'd4) || ({1'b0, carry_count_q} >= char_width_q);

	always_comb begin
		cnt_d   = carry_count_q;
		w_d     = char_width_q;
		wr_en   = 1'b0;
		wr_idx  = carry_count_q;
		new_num = 3'd0;
		for (int i = 0; i < MAX_RESULTS; i++) begin
			new_res[i] = '{out_byte: 8'h00, char_end: 1'b1, status: ST_INVALID};
		end
		if (kind_s1 == KIND_END) begin
			cnt_d   = 2'd0;
			w_d     = 3'd0;
			new_num = 3'd1;
			new_res[0].status = (carry_count_q != 2'd0) ? ST_INCOMPLETE : ST_DONE;
		end else if (new_char) begin
			cnt_d = 2'd0;
			w_d   = 3'd0;
			if (lw == 3'd0) begin
				new_num = 3'd1;
			end else if (lw == 3'd1) begin
				new_num = 3'd1;
				new_res[0] = '{out_byte: byte_s1, char_end: 1'b1, status: ST_BYTE};
			end else begin
				wr_en  = 1'b1;
				wr_idx = 2'd0;
				cnt_d  = 2'd1;
				w_d    = lw;
			end
		end else if ({1'b0, carry_count_q} + 3'd1 < char_width_q) begin
			wr_en = 1'b1;
			cnt_d = carry_count_q + 2'd1;
		end else begin
			cnt_d   = 2'd0;
			w_d     = 3'd0;
			new_num = 3'd1;
			if (char_ok(carry_bytes_q[0], c1, c2, byte_s1, char_width_q)) begin
				new_num = char_width_q;
				new_res[0] = '{out_byte: carry_bytes_q[0], char_end: 1'b0, status: ST_BYTE};
				new_res[1] = '{out_byte: c1, char_end: (char_width_q == 3'd2),
					status: ST_BYTE};
				new_res[2] = '{out_byte: c2, char_end: (char_width_q == 3'd3),
					status: ST_BYTE};
				new_res[3] = '{out_byte: byte_s1, char_end: 1'b1, status: ST_BYTE};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ch.ready) begin
			valid_s1 <= byte_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ch.valid && byte_ch.ready) begin
			kind_s1 <= byte_ch.kind;
			byte_s1 <= byte_ch.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_count_q <= 2'd0;
			char_width_q  <= 3'd0;
		end else if (advance) begin
			carry_count_q <= cnt_d;
			char_width_q  <= w_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && wr_en) begin
			case (wr_idx)
				2'd0: carry_bytes_q[0] <= byte_s1;
				2'd1: carry_bytes_q[1] <= byte_s1;
				2'd2: carry_bytes_q[2] <= byte_s1;
				default: carry_bytes_q[2] <= carry_bytes_q[2];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 3'd0;
			idx_q <= 2'd0;
		end else if (advance && new_num != 3'd0) begin
			rem_q <= new_num;
			idx_q <= 2'd0;
		end else if (out_take) begin
			rem_q <= rem_q - 3'd1;
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && new_num != 3'd0) begin
			for (int i = 0; i < MAX_RESULTS; i++) begin
				res_q[i] <= new_res[i];
			end
		end
	end

	`ASSERT_IMPLIES(a_carry_fits, clk, arst_n, carry_count_q != 2'd0, (char_width_q >= 3'd2) && (char_width_q <= 3'd4) && ({1'b0, carry_count_q} < char_width_q))
	`ASSERT_IMPLIES(a_buffer_bound, clk, arst_n, 1'b1, rem_q <= 3'd4)
	`ASSERT_IMPLIES(a_status_ends, clk, arst_n, result_ch.valid && (result_ch.status != ST_BYTE), result_ch.char_end && (result_ch.out_byte == 8'h00))
	`ASSERT_NEXT(a_held_item, clk, arst_n, valid_s1 && !buf_free, valid_s1 && $stable(byte_s1) && $stable(kind_s1))

endmodule

/* verif/tb_utf8_stream_validator_top.sv */
// Self-checking testbench for the UTF-8 stream validator: predicted results, random stalls
module tb_utf8_stream_validator_top;
	import utf8v_pkg::*;

	class utf8_scoreboard;
		result_t    expected_q[$];
		logic [7:0] held[3];
		logic [1:0] held_count;
		logic [2:0] held_width;
		int         errors;
		int         n_checked;
		int         n_bytes;
		int         n_invalid;
		int         n_incomplete;
		int         n_done;

		function new();
			held_count   = 2'd0;
			held_width   = 3'd0;
			errors       = 0;
			n_checked    = 0;
			n_bytes      = 0;
			n_invalid    = 0;
			n_incomplete = 0;
			n_done       = 0;
		endfunction

		function void push_result(logic [7:0] b, logic last, stat_t st);
			result_t r;
			r.out_byte = b;
			r.char_end = last;
			r.status   = st;
			expected_q.push_back(r);
		endfunction

		function logic [2:0] byte_span(logic [7:0] b);
			if (b <= ASCII_MAX) return 3'd1;
			if (b >= LEAD2_MIN && b <= LEAD2_MAX) return 3'd2;
			if (b >= LEAD3_MIN && b <= LEAD3_MAX) return 3'd3;
			if (b >= LEAD4_MIN && b <= LEAD4_MAX) return 3'd4;
			return 3'd0;
		endfunction

		function bit well_formed(logic [7:0] chr[4], logic [2:0] w);
			for (int i = 1; i < w; i++) begin
				if (chr[i] < CONT_MIN || chr[i] > CONT_MAX) return 1'b0;
			end
			if (chr[0] == LEAD3_MIN && chr[1] < SECOND_A0) return 1'b0;
			if (chr[0] == LEAD_SURR && chr[1] >= SECOND_A0) return 1'b0;
			if (chr[0] == LEAD4_MIN && chr[1] < SECOND_90) return 1'b0;
			if (chr[0] == LEAD4_MAX && chr[1] >= SECOND_90) return 1'b0;
			return 1'b1;
		endfunction

		function void note_beat(logic kind, logic [7:0] b);
			logic [7:0] chr[4];
			logic [2:0] span;
			if (kind == KIND_END) begin
				push_result(8'h00, 1'b1, (held_count != 2'd0) ? ST_INCOMPLETE : ST_DONE);
				held_count = 2'd0;
				held_width = 3'd0;
			end else if (held_count == 2'd0 || held_width < 3'd2 || held_width > 3'd4 ||
					held_count >= held_width) begin
				held_count = 2'd0;
				held_width = 3'd0;
				span = byte_span(b);
				if (span == 3'd0) begin
					push_result(8'h00, 1'b1, ST_INVALID);
				end else if (span == 3'd1) begin
					push_result(b, 1'b1, ST_BYTE);
				end else begin
					held[0]    = b;
					held_count = 2'd1;
					held_width = span;
				end
			end else if (held_count + 3'd1 < held_width) begin
				held[held_count] = b;
				held_count       = held_count + 2'd1;
			end else begin
				span = held_width;
				for (int i = 0; i < 4; i++) chr[i] = 8'h00;
				for (int i = 0; i < held_count; i++) chr[i] = held[i];
				chr[held_count] = b;
				held_count = 2'd0;
				held_width = 3'd0;
				if (!well_formed(chr, span)) begin
					push_result(8'h00, 1'b1, ST_INVALID);
				end else begin
					for (int i = 0; i < span; i++) push_result(chr[i], i + 1 == span, ST_BYTE);
				end
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, got byte %h end %b status %0d",
					$time, got.out_byte, got.char_end, got.status);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			n_checked++;
			if (got.out_byte !== want.out_byte) begin
				$display("%0t: out_byte expected %h got %h", $time, want.out_byte, got.out_byte);
				errors++;
			end
			if (got.char_end !== want.char_end) begin
				$display("%0t: char_end expected %b got %b", $time, want.char_end, got.char_end);
				errors++;
			end
			if (got.status !== want.status) begin
				$display("%0t: status expected %0d got %0d", $time, want.status, got.status);
				errors++;
			end
			case (want.status)
				ST_BYTE:       n_bytes++;
				ST_INVALID:    n_invalid++;
				ST_INCOMPLETE: n_incomplete++;
				default:       n_done++;
			endcase
		endfunction

		function void drain_check();
			if (expected_q.size() != 0) begin
				$display("%0t: %0d results expected, none received", $time, expected_q.size());
				errors += expected_q.size();
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   steady;
	int   beats_taken;
	int   end_beats;

	utf8_scoreboard sb;

	utf8v_in_if  byte_ch();
	utf8v_out_if result_ch();

	utf8_stream_validator_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_ch   (byte_ch),
		.result_ch (result_ch)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic int idle_cycles();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 65) return 0;
		if (pick < 88) return $urandom_range(1, 3);
		if (pick < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	always @(posedge clk) begin
		result_t got;
		if (arst_n) begin
			if (byte_ch.valid === 1'b1 && byte_ch.ready === 1'b1) begin
				sb.note_beat(byte_ch.kind, byte_ch.data_byte);
				beats_taken++;
				if (byte_ch.kind == KIND_END) end_beats++;
			end
			if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
				got.out_byte = result_ch.out_byte;
				got.char_end = result_ch.char_end;
				got.status   = stat_t'(result_ch.status);
				sb.check_result(got);
			end
		end
	end

	task automatic send_beat(input logic kind, input logic [7:0] b);
		int n;
		n = steady ? 0 : idle_cycles();
		if (n > 0) begin
			byte_ch.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		byte_ch.valid     <= 1'b1;
		byte_ch.kind      <= kind;
		byte_ch.data_byte <= b;
		do @(posedge clk); while (byte_ch.ready !== 1'b1);
	endtask

	task automatic send_data(input logic [7:0] b);
		send_beat(KIND_DATA, b);
	endtask

	task automatic send_end(input logic [7:0] b);
		send_beat(KIND_END, b);
	endtask

	function automatic logic [7:0] cont_byte();
		return 8'($urandom_range(CONT_MIN, CONT_MAX));
	endfunction

	function automatic logic [7:0] broken_cont();
		return $urandom_range(0, 1) ? 8'($urandom_range(8'h00, ASCII_MAX)) :
			8'($urandom_range(8'hC0, 8'hFF));
	endfunction

	// flaw: 0 none, 1 bad continuation, 2 second-byte limit broken, 3 cut short by end
	task automatic send_multibyte(input int span, input int flaw);
		logic [7:0] lead;
		logic [7:0] second;
		int         bad_pos;
		int         sent;
		case (span)
			2:       lead = 8'($urandom_range(LEAD2_MIN, LEAD2_MAX));
			3:       lead = 8'($urandom_range(LEAD3_MIN, LEAD3_MAX));
			default: lead = 8'($urandom_range(LEAD4_MIN, LEAD4_MAX));
		endcase
		if (flaw == 2) begin
			if (span == 3) lead = $urandom_range(0, 1) ? LEAD3_MIN : LEAD_SURR;
			else lead = $urandom_range(0, 1) ? LEAD4_MIN : LEAD4_MAX;
		end
		case (lead)
			LEAD3_MIN: second = (flaw == 2) ? 8'($urandom_range(CONT_MIN, 8'h9F)) :
				8'($urandom_range(SECOND_A0, CONT_MAX));
			LEAD_SURR: second = (flaw == 2) ? 8'($urandom_range(SECOND_A0, CONT_MAX)) :
				8'($urandom_range(CONT_MIN, 8'h9F));
			LEAD4_MIN: second = (flaw == 2) ? 8'($urandom_range(CONT_MIN, 8'h8F)) :
				8'($urandom_range(SECOND_90, CONT_MAX));
			LEAD4_MAX: second = (flaw == 2) ? 8'($urandom_range(SECOND_90, CONT_MAX)) :
				8'($urandom_range(CONT_MIN, 8'h8F));
			default:   second = cont_byte();
		endcase
		bad_pos = (flaw == 1) ? $urandom_range(1, span - 1) : 0;
		sent = (flaw == 3) ? $urandom_range(1, span - 1) : span;
		send_data(lead);
		for (int i = 1; i < sent; i++) begin
			if (i == bad_pos) send_data(broken_cont());
			else if (i == 1) send_data(second);
			else send_data(cont_byte());
		end
		if (flaw == 3) send_end(8'($urandom));
	endtask

	task automatic send_random_sequence();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 22) begin
			send_data(8'($urandom_range(8'h00, ASCII_MAX)));
		end else if (pick < 40) begin
			send_multibyte(2, 0);
		end else if (pick < 60) begin
			send_multibyte(3, 0);
		end else if (pick < 76) begin
			send_multibyte(4, 0);
		end else if (pick < 81) begin
			send_data($urandom_range(0, 1) ? 8'($urandom_range(CONT_MIN, 8'hC1)) :
				8'($urandom_range(8'hF5, 8'hFF)));
		end else if (pick < 86) begin
			send_multibyte($urandom_range(2, 4), 1);
		end else if (pick < 90) begin
			send_multibyte($urandom_range(3, 4), 2);
		end else if (pick < 94) begin
			send_multibyte($urandom_range(2, 4), 3);
		end else if (pick < 97) begin
			send_end(8'($urandom));
		end else begin
			send_data(8'($urandom));
		end
	endtask

	initial begin
		result_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			int n;
			n = steady ? 0 : idle_cycles();
			if (n > 0) begin
				result_ch.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	end

	initial begin
		int directed_beats;
		int waited;
		sb          = new();
		steady      = 1'b0;
		beats_taken = 0;
		end_beats   = 0;
		arst_n      = 1'b0;
		byte_ch.valid     <= 1'b0;
		byte_ch.kind      <= KIND_DATA;
		byte_ch.data_byte <= 8'h00;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// field extremes and bad lead bytes
		send_data(8'h00);
		send_data(ASCII_MAX);
		send_data(CONT_MIN);
		send_data(8'hC1);
		send_data(8'hF5);
		send_data(8'hFF);
		send_data(LEAD2_MIN);
		send_data(CONT_MIN);
		// overlong, surrogate and above-range second bytes
		send_data(LEAD3_MIN);
		send_data(8'h9F);
		send_data(CONT_MIN);
		send_data(LEAD_SURR);
		send_data(SECOND_A0);
		send_data(CONT_MAX);
		send_data(LEAD4_MIN);
		send_data(8'h8F);
		send_data(CONT_MAX);
		send_data(CONT_MAX);
		send_data(LEAD4_MAX);
		send_data(SECOND_90);
		send_data(CONT_MIN);
		send_data(CONT_MIN);
		// bad continuation, then end with and without a carry
		send_data(LEAD2_MAX);
		send_data(8'h41);
		send_data(8'hE1);
		send_end(8'h00);
		send_end(8'hFF);
		directed_beats = beats_taken + 1;

		while (beats_taken < directed_beats + 72) begin
			if ($urandom_range(0, 99) < 8) steady = ~steady;
			send_random_sequence();
		end
		byte_ch.valid <= 1'b0;
		steady = 1'b0;

		waited = 0;
		while (sb.expected_q.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);
		sb.drain_check();

		$display("Sent %0d beats (%0d end markers); checked %0d results:", beats_taken,
			end_beats, sb.n_checked);
		$display("  %0d character bytes, %0d invalid, %0d incomplete ends, %0d clean ends",
			sb.n_bytes, sb.n_invalid, sb.n_incomplete, sb.n_done);
		if (sb.errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("Mismatches found");
		$finish;
	end

endmodule
